// File: src/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg: shared types, constants and helpers of the set-associative cache
// Geometry of the cache, transaction payloads, configuration view and the
// helpers that clamp configuration values to the supported range.
// ----------------------------------------------------------------------------
package salc_pkg;

   // Cache geometry
   localparam int MAX_SET_BITS  = 6;
   localparam int WAYS          = 8;
   localparam int ADDR_BITS     = 48;
   localparam int NUM_SETS      = 1 << MAX_SET_BITS;
   localparam int SET_IDX_BITS  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_BITS      = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RANK_BITS     = WAY_BITS;
   localparam int WAY_CNT_BITS  = $clog2(WAYS + 1);

   // Configuration register widths
   localparam int SET_CFG_BITS   = 3;
   localparam int WAYS_CFG_BITS  = 4;
   localparam int BLOCK_CFG_BITS = 6;
   localparam int CSR_DATA_BITS  = 6;
   localparam int CSR_INDEX_BITS = 2;

   // Shift amounts cover block_bits plus set_bits
   localparam int SHIFT_BITS = $clog2((1 << BLOCK_CFG_BITS) + MAX_SET_BITS + 1);

   // Queue depths
   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int Q_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   // Access kinds
   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_STORE  = 2'd1;
   localparam logic [1:0] MODE_MODIFY = 2'd2;
   localparam logic [1:0] MODE_NONE   = 2'd3;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAYS_USED  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLOCK_BITS = 2'd2;

   typedef struct packed {
      logic [1:0]           mode;
      logic [ADDR_BITS-1:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0] hit_count;
      logic       missed;
      logic       evicted;
   } rsp_type;

   typedef struct packed {
      logic [SET_CFG_BITS-1:0]   set_bits;
      logic [WAYS_CFG_BITS-1:0]  ways_used;
      logic [BLOCK_CFG_BITS-1:0] block_bits;
   } cfg_type;

   // Classified access handed from the front end to the back end
   typedef struct packed {
      logic [1:0]              mode;
      logic [SET_IDX_BITS-1:0] set_idx;
      logic [ADDR_BITS-1:0]    tag;
   } job_type;

   // Per-set line state: valid bits and recency ranks (rank 0 is newest)
   typedef struct packed {
      logic [WAYS-1:0]                valid;
      logic [WAYS-1:0][RANK_BITS-1:0] rank;
   } meta_type;

   // Clamp set_bits to the supported index width
   function automatic logic [SHIFT_BITS-1:0] salc_eff_set_bits(
      input logic [SET_CFG_BITS-1:0] s);
      logic [SHIFT_BITS-1:0] r;
      if (32'(s) > MAX_SET_BITS) begin
         r = SHIFT_BITS'(MAX_SET_BITS);
      end else begin
         r = SHIFT_BITS'(s);
      end
      return r;
   endfunction

   // Clamp ways_used to 1..WAYS
   function automatic logic [WAY_CNT_BITS-1:0] salc_eff_ways(
      input logic [WAYS_CFG_BITS-1:0] n);
      logic [WAY_CNT_BITS-1:0] r;
      if (n == '0) begin
         r = WAY_CNT_BITS'(1);
      end else if (32'(n) > WAYS) begin
         r = WAY_CNT_BITS'(WAYS);
      end else begin
         r = WAY_CNT_BITS'(n);
      end
      return r;
   endfunction

endpackage

// File: src/salc_front.sv
// ----------------------------------------------------------------------------
// salc_front: request intake and classification
// Splits each accepted address into set index and tag under the current
// configuration and holds the classified accesses in a short queue.
// ----------------------------------------------------------------------------
module salc_front import salc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    job_valid,
   output job_type job,
   input  logic    job_pop
);

   job_type                 q_ff [QUEUE_DEPTH];
   logic [Q_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [SHIFT_BITS-1:0]   sb, bb;
   logic [ADDR_BITS-1:0]    addr_off;
   logic [SET_IDX_BITS-1:0] set_mask;
   job_type                 job_in;
   logic                    push_ok, pop_ok;

   // Classify the incoming address
   always_comb begin
      sb             = salc_eff_set_bits(cfg.set_bits);
      bb             = SHIFT_BITS'(cfg.block_bits);
      addr_off       = req_data.address >> bb;
      set_mask       = ~({SET_IDX_BITS{1'b1}} << sb);
      job_in.mode    = req_data.mode;
      job_in.set_idx = addr_off[SET_IDX_BITS-1:0] & set_mask;
      job_in.tag     = req_data.address >> (bb + sb);
   end

   assign req_full  = (cnt_ff == Q_CNT_BITS'(QUEUE_DEPTH));
   assign job_valid = (cnt_ff != '0);
   assign job       = q_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = job_pop && job_valid;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the classified access
   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

// File: src/salc_back.sv
// ----------------------------------------------------------------------------
// salc_back: cache lookup and update sequencer
// Reads the set row, compares the ways, picks the hit or replacement way,
// updates recency ranks and tags, and produces one result per access.
// ----------------------------------------------------------------------------
module salc_back import salc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    job_valid,
   input  job_type job,
   output logic    job_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp_out
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOK   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Row memories: one row per set
   logic [WAYS-1:0][ADDR_BITS-1:0] tag_mem [NUM_SETS];
   meta_type                       meta_mem [NUM_SETS];
   logic [NUM_SETS-1:0]            row_live_ff;

   logic [WAYS-1:0][ADDR_BITS-1:0] tag_rd_ff;
   meta_type                       meta_rd_ff;
   logic                           live_rd_ff;
   job_type                        cur_ff;

   logic [WAY_BITS-1:0] sel_way_ff, sel_way_in;
   logic                hit_ff, hit_in;
   logic                evict_ff, evict_in;

   logic [WAY_CNT_BITS-1:0]        nways;
   logic [WAYS-1:0]                in_use;
   meta_type                       meta_cur, meta_new;
   logic [WAYS-1:0]                match, free;
   logic [WAY_BITS-1:0]            hit_way, free_way, lru_way;
   logic [RANK_BITS-1:0]           best_rank;
   logic                           old_valid;
   logic [RANK_BITS-1:0]           old_rank;
   logic                           rd_en, commit, meta_we, tag_we;

   assign nways    = salc_eff_ways(cfg.ways_used);
   assign meta_cur = live_rd_ff ? meta_rd_ff : '0;

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         in_use[w] = (WAY_CNT_BITS'(w) < nways);
      end
   end

   // Compare ways and choose the line to use
   always_comb begin
      hit_way   = '0;
      free_way  = '0;
      lru_way   = '0;
      best_rank = meta_cur.rank[0];
      for (int w = 0; w < WAYS; w++) begin
         match[w] = in_use[w] && meta_cur.valid[w] && (tag_rd_ff[w] == cur_ff.tag);
         free[w]  = in_use[w] && !meta_cur.valid[w];
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_way = WAY_BITS'(w);
         end
         if (free[w]) begin
            free_way = WAY_BITS'(w);
         end
      end
      for (int w = 1; w < WAYS; w++) begin
         if (in_use[w] && (meta_cur.rank[w] > best_rank)) begin
            lru_way   = WAY_BITS'(w);
            best_rank = meta_cur.rank[w];
         end
      end
      hit_in   = |match;
      evict_in = !(|match) && !(|free);
      if (|match) begin
         sel_way_in = hit_way;
      end else if (|free) begin
         sel_way_in = free_way;
      end else begin
         sel_way_in = lru_way;
      end
   end

   // Make the selected way the most recently used one
   always_comb begin
      old_valid      = meta_cur.valid[sel_way_ff];
      old_rank       = meta_cur.rank[sel_way_ff];
      meta_new       = meta_cur;
      meta_new.valid = meta_cur.valid | (WAYS'(1) << sel_way_ff);
      for (int v = 0; v < WAYS; v++) begin
         if (WAY_BITS'(v) == sel_way_ff) begin
            meta_new.rank[v] = '0;
         end else if (in_use[v] && meta_cur.valid[v]
                      && (!old_valid || (meta_cur.rank[v] < old_rank))
                      && (meta_cur.rank[v] != RANK_BITS'(WAYS - 1))) begin
            meta_new.rank[v] = meta_cur.rank[v] + 1'b1;
         end
      end
   end

   // Sequence one access at a time
   always_comb begin
      state_in = state_ff;
      rd_en    = 1'b0;
      commit   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               rd_en    = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!rsp_full) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign job_pop  = rd_en;
   assign rsp_push = commit;
   assign meta_we  = commit && (cur_ff.mode != MODE_NONE);
   assign tag_we   = meta_we && !hit_ff;

   // Build the result
   always_comb begin
      rsp_out = '0;
      if (cur_ff.mode != MODE_NONE) begin
         if (hit_ff) begin
            rsp_out.hit_count = (cur_ff.mode == MODE_MODIFY) ? 2'd2 : 2'd1;
         end else begin
            rsp_out.hit_count = (cur_ff.mode == MODE_MODIFY) ? 2'd1 : 2'd0;
            rsp_out.missed    = 1'b1;
            rsp_out.evicted   = evict_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         row_live_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (meta_we) begin
            row_live_ff[cur_ff.set_idx] <= 1'b1;
         end
      end
   end

   // Hold the access and its way choice
   always_ff @(posedge clock) begin
      if (rd_en) begin
         cur_ff     <= job;
         live_rd_ff <= row_live_ff[job.set_idx];
      end
      if (state_ff == ST_LOOK) begin
         sel_way_ff <= sel_way_in;
         hit_ff     <= hit_in;
         evict_ff   <= evict_in;
      end
   end

   // Row memories: registered read, write-back on commit
   always_ff @(posedge clock) begin
      if (rd_en) begin
         tag_rd_ff  <= tag_mem[job.set_idx];
         meta_rd_ff <= meta_mem[job.set_idx];
      end
      if (tag_we) begin
         tag_mem[cur_ff.set_idx][sel_way_ff] <= cur_ff.tag;
      end
      if (meta_we) begin
         meta_mem[cur_ff.set_idx] <= meta_new;
      end
   end

endmodule

// File: src/salc_rsp_queue.sv
// ----------------------------------------------------------------------------
// salc_rsp_queue: result queue
// Holds finished results until the consumer takes them, so the lookup
// engine can move on to the next access.
// ----------------------------------------------------------------------------
module salc_rsp_queue import salc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   rsp_type               q_ff [QUEUE_DEPTH];
   logic [Q_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                  push_ok, pop_ok;

   assign full      = (cnt_ff == Q_CNT_BITS'(QUEUE_DEPTH));
   assign rsp_empty = (cnt_ff == '0);
   assign rsp_data  = q_ff[rd_ptr_ff];
   assign push_ok   = push && !full;
   assign pop_ok    = rsp_pop && !rsp_empty;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the result
   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/set_assoc_lru_cache_sim_core.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_core: set-associative cache model with LRU
// Top level: configuration registers, front end, lookup engine and
// result queue.
// ----------------------------------------------------------------------------
// Each access goes through the lookup engine in steps: ST_IDLE reads the set
// row from the tag and line-state memories, ST_LOOK compares the ways and
// picks the hit or replacement way, and ST_UPDATE updates recency and writes
// the row back once the result queue has room. The engine takes the next
// access only after the current one is done. Two-entry queues at the input
// and at the result side let requests be taken and results be drained
// independently. Line state resets through one valid flag per set, so the
// block accepts accesses right after reset with no clearing pass. Write the
// registers only while no access is outstanding.
module set_assoc_lru_cache_sim_core import salc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  req_type                   req_data,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output rsp_type                   rsp_data,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   job_type job;
   logic    job_valid, job_pop;
   logic    back_push, rsp_q_full;
   rsp_type back_rsp;

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SET_BITS:   cfg_in.set_bits   = csr_wdata[SET_CFG_BITS-1:0];
            CSR_WAYS_USED:  cfg_in.ways_used  = csr_wdata[WAYS_CFG_BITS-1:0];
            CSR_BLOCK_BITS: cfg_in.block_bits = csr_wdata[BLOCK_CFG_BITS-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_bits   <= '0;
         cfg_ff.ways_used  <= WAYS_CFG_BITS'(1);
         cfg_ff.block_bits <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   salc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop)
   );

   salc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop),
      .rsp_full  (rsp_q_full),
      .rsp_push  (back_push),
      .rsp_out   (back_rsp)
   );

   salc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_rsp),
      .full      (rsp_q_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // Never drop a result into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      back_push |-> !rsp_q_full)
      else $error("result pushed into full queue");

   // Only take work that is there
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> job_valid)
      else $error("lookup engine popped empty front queue");

   // An eviction only happens on a miss
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.evicted) |-> rsp_data.missed)
      else $error("eviction reported without miss");

   // Two hits only come from a modify hit
   a_two_hits: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.hit_count[1]) |-> (!rsp_data.missed && !rsp_data.hit_count[0]))
      else $error("inconsistent hit count");
`endif

endmodule
